@@ hw/rtl/bba_pkg.sv @@
// Shared request codes, status codes and field widths of the block bitmap allocator.
`default_nettype none

package bba_pkg;

	localparam int BLK_W = 12;
	localparam int CNT_W = 13;
	localparam int ST_W  = 2;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_READ    = 2'd2,
		REQ_WRITE   = 2'd3
	} req_t;

	localparam logic [ST_W-1:0] STS_OK    = 2'd0;
	localparam logic [ST_W-1:0] STS_FULL  = 2'd1;
	localparam logic [ST_W-1:0] STS_RANGE = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/block_bitmap_allocator_core.sv @@
// First-fit bitmap block allocator with free-block count, word-serial scan over a bitmap RAM.
// Scan: an item walks the bitmap RAM one word per cycle from word 0 (one read port).
//   Allocate walks until it finds a free block or passes total_blocks; release, read and write
//   walk to the word that holds block_number; a range or empty-count miss skips the scan.
// Throughput: one item at a time; the next item is taken once the result is in the output reg.
// Reset: arst_n clears control state, then a clearing pass writes MAP_WORDS zero words, one a
//   cycle, with s_tready low; total_blocks and the count reset to min(4096, NUM_BLOCKS).
`default_nettype none

module block_bitmap_allocator_core #(
	parameter int NUM_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: total_blocks
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_wdata,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] block_number, [12] bit_value
	input  wire logic [1:0]  s_tuser,   // [1:0] req_type
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [11:0] result_block, [12] bit_read,
	                                    // [25:13] free_left, [27:26] status
);

	localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int SPAN      = MAP_WORDS * WORD_BITS;
	localparam int CW0       = $clog2(SPAN + WORD_BITS + 1);
	localparam int CW        = (CW0 > bba_pkg::CNT_W) ? CW0 : bba_pkg::CNT_W;
	localparam int OW        = $clog2(WORD_BITS);
	localparam int KW        = $clog2(WORD_BITS + 1);
	localparam int LIM_RST   = (NUM_BLOCKS < 4096) ? NUM_BLOCKS : 4096;
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_OUT
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                clr_q;
	logic [CW-1:0]                lim_q;
	logic [bba_pkg::CNT_W-1:0]    count_q;
	bba_pkg::req_t                req_q;
	logic [bba_pkg::BLK_W-1:0]    blk_q;
	logic                         val_q;
	logic [AW-1:0]                raddr_q;
	logic [CW-1:0]                rbase_q;
	logic                         dvalid_s1;
	logic [CW-1:0]                dbase_s1;
	logic [AW-1:0]                daddr_s1;
	logic [WORD_BITS-1:0]         rd_word_s1;
	logic [bba_pkg::BLK_W-1:0]    res_blk_q;
	logic                         res_rd_q;
	logic [bba_pkg::ST_W-1:0]     res_st_q;
	logic                         m_tvalid_q;
	logic [31:0]                  m_tdata_q;

	logic [WORD_BITS-1:0]         map_mem [MAP_WORDS];

	bba_pkg::req_t                in_req;
	logic [bba_pkg::BLK_W-1:0]    in_blk;
	logic                         in_val;
	logic [CW-1:0]                new_lim;
	logic                         past_end;
	logic [CW-1:0]                rem;
	logic [KW-1:0]                rem_n;
	logic [WORD_BITS-1:0]         cand;
	logic                         hit;
	logic [OW-1:0]                hit_off;
	logic [CW-1:0]                blk_diff;
	logic                         in_word;
	logic [OW-1:0]                sel_off;
	logic [OW-1:0]                sel_pos;
	logic                         new_bit;
	logic [WORD_BITS-1:0]         new_word;
	logic                         is_alloc;
	logic                         found;
	logic                         fail;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [WORD_BITS-1:0]         mem_wdata;
	logic [CW-1:0]                hit_blk;

	assign in_req   = bba_pkg::req_t'(s_tuser);
	assign in_blk   = s_tdata[11:0];
	assign in_val   = s_tdata[12];
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign new_lim  = (CW'(cfg_wdata) > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(cfg_wdata);
	assign is_alloc = (req_q == bba_pkg::REQ_ALLOC);

	always_comb begin
		past_end = (dbase_s1 >= lim_q);
		rem      = lim_q - dbase_s1;
		rem_n    = (rem >= CW'(WORD_BITS)) ? KW'(WORD_BITS) : rem[KW-1:0];
		for (int k = 0; k < WORD_BITS; k++) begin
			cand[k] = ~rd_word_s1[WORD_BITS-1-k] & (KW'(k) < rem_n);
		end
		hit     = 1'b0;
		hit_off = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (cand[k]) begin
				hit     = 1'b1;
				hit_off = OW'(k);
			end
		end
		blk_diff = CW'(blk_q) - dbase_s1;
		in_word  = (blk_diff < CW'(WORD_BITS));
		sel_off  = is_alloc ? hit_off : blk_diff[OW-1:0];
		sel_pos  = OW'(WORD_BITS - 1) - sel_off;
		hit_blk  = dbase_s1 + CW'(hit_off);
		unique case (req_q)
			bba_pkg::REQ_ALLOC:   new_bit = 1'b1;
			bba_pkg::REQ_RELEASE: new_bit = 1'b0;
			bba_pkg::REQ_READ:    new_bit = rd_word_s1[sel_pos];
			bba_pkg::REQ_WRITE:   new_bit = val_q;
			default:              new_bit = 1'b0;
		endcase
		new_word          = rd_word_s1;
		new_word[sel_pos] = new_bit;
		found = dvalid_s1 && (is_alloc ? (!past_end && hit) : in_word);
		fail  = dvalid_s1 && is_alloc && past_end;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = daddr_s1;
		mem_wdata = new_word;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_SCAN && found && req_q != bba_pkg::REQ_READ) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rd_word_s1 <= map_mem[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			lim_q      <= CW'(LIM_RST);
			count_q    <= bba_pkg::CNT_W'(LIM_RST);
			req_q      <= bba_pkg::REQ_ALLOC;
			blk_q      <= '0;
			val_q      <= 1'b0;
			raddr_q    <= '0;
			rbase_q    <= '0;
			dvalid_s1  <= 1'b0;
			dbase_s1   <= '0;
			daddr_s1   <= '0;
			res_blk_q  <= '0;
			res_rd_q   <= 1'b0;
			res_st_q   <= bba_pkg::STS_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				lim_q   <= new_lim;
				count_q <= new_lim[bba_pkg::CNT_W-1:0];
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					raddr_q   <= '0;
					rbase_q   <= '0;
					dvalid_s1 <= 1'b0;
					if (s_tvalid) begin
						req_q     <= in_req;
						blk_q     <= in_blk;
						val_q     <= in_val;
						res_blk_q <= in_blk;
						res_rd_q  <= 1'b0;
						res_st_q  <= bba_pkg::STS_OK;
						state_q   <= ST_SCAN;
						if (in_req == bba_pkg::REQ_ALLOC) begin
							res_blk_q <= '0;
							if (count_q == '0) begin
								res_st_q <= bba_pkg::STS_FULL;
								state_q  <= ST_OUT;
							end
						end else if (CW'(in_blk) >= lim_q) begin
							res_st_q <= bba_pkg::STS_RANGE;
							state_q  <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					dvalid_s1 <= 1'b1;
					dbase_s1  <= rbase_q;
					daddr_s1  <= raddr_q;
					rbase_q   <= rbase_q + CW'(WORD_BITS);
					if (raddr_q != LAST_WORD) begin
						raddr_q <= raddr_q + AW'(1);
					end
					if (fail) begin
						res_st_q <= bba_pkg::STS_FULL;
						state_q  <= ST_OUT;
					end else if (found) begin
						state_q <= ST_OUT;
						unique case (req_q)
							bba_pkg::REQ_ALLOC: begin
								res_blk_q <= hit_blk[bba_pkg::BLK_W-1:0];
								count_q   <= count_q - bba_pkg::CNT_W'(1);
							end
							bba_pkg::REQ_RELEASE: begin
								if (CW'(count_q) < lim_q) begin
									count_q <= count_q + bba_pkg::CNT_W'(1);
								end
							end
							bba_pkg::REQ_READ: begin
								res_rd_q <= rd_word_s1[sel_pos];
							end
							bba_pkg::REQ_WRITE: begin
								if (val_q) begin
									if (count_q != '0) begin
										count_q <= count_q - bba_pkg::CNT_W'(1);
									end
								end else if (CW'(count_q) < lim_q) begin
									count_q <= count_q + bba_pkg::CNT_W'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, res_st_q, count_q, res_rd_q, res_blk_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= lim_q)
		else $error("free count above bound");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27:26] == bba_pkg::STS_FULL) |-> (m_tdata[11:0] == '0))
		else $error("failed allocate returns nonzero block");

	a_range_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27:26] != bba_pkg::STS_OK) |-> !m_tdata[12])
		else $error("bit_read set on failed transaction");

	a_scan_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("bitmap written while idle");

endmodule

`default_nettype wire
